[rtl/core/http_chunked_body_decoder_macros.svh]
// assertion macros shared by the chunked body decoder rtl
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define HCBD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define HCBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/hcbd_pkg.sv]
// types, codes and helper functions for the chunked body decoder
`default_nettype none

package hcbd_pkg;

   localparam int BYTE_W            = 8;
   localparam int STATUS_W          = 3;
   localparam int SIZE_BITS_DEFAULT = 32;
   localparam int HEX_DIGIT_W       = 4;

   // bytes skipped after each chunk's data
   localparam logic [1:0] SKIP_BYTES = 2'd2;

   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

   typedef enum logic [2:0] {
      PH_LINE     = 3'd0,
      PH_LINE_OVF = 3'd1,
      PH_DATA     = 3'd2,
      PH_SKIP     = 3'd3,
      PH_STOP     = 3'd4
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ZERO     = 3'd0,
      ST_BOUNDARY = 3'd1,
      ST_TRUNC    = 3'd2,
      ST_NODIGIT  = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   // parser control state, the size counters travel separately
   typedef struct packed {
      phase_type  phase;
      logic       digit_seen;
      logic       number_closed;
      logic       prior_was_cr;
      logic [1:0] skip_left;
      status_type stop_status;
   } ctl_type;

   localparam ctl_type CTL_RESET = '{
      phase:         PH_LINE,
      digit_seen:    1'b0,
      number_closed: 1'b0,
      prior_was_cr:  1'b0,
      skip_left:     2'd0,
      stop_status:   ST_BOUNDARY
   };

   // one result item
   typedef struct packed {
      logic                payload_valid;
      logic [BYTE_W-1:0]   payload_byte;
      logic                body_done;
      logic [STATUS_W-1:0] end_status;
   } rslt_type;

   // hex digit decode: {is_digit, value}
   function automatic logic [HEX_DIGIT_W:0] hex_digit(input logic [BYTE_W-1:0] b);
      logic [HEX_DIGIT_W:0] r;
      r = '0;
      if (b inside {[8'h30:8'h39]}) begin
         r = {1'b1, HEX_DIGIT_W'(b - 8'h30)};
      end else if (b inside {[8'h61:8'h66]}) begin
         r = {1'b1, HEX_DIGIT_W'(b - 8'h57)};
      end else if (b inside {[8'h41:8'h46]}) begin
         r = {1'b1, HEX_DIGIT_W'(b - 8'h37)};
      end
      return r;
   endfunction

   // space, tab, lf, vt, ff, cr
   function automatic logic is_space(input logic [BYTE_W-1:0] b);
      return (b == 8'h20) || (b inside {[8'h09:8'h0D]});
   endfunction

endpackage

`default_nettype wire

[rtl/core/hcbd_if.sv]
// valid/ready channel interfaces for body bytes in and decoded items out
`default_nettype none

interface hcbd_req_if;
   logic                          valid;
   logic                          ready;
   logic [hcbd_pkg::BYTE_W-1:0]   body_byte;
   logic                          body_last;

   modport source (output valid, output body_byte, output body_last, input ready);
   modport sink   (input valid, input body_byte, input body_last, output ready);
endinterface

interface hcbd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          payload_valid;
   logic [hcbd_pkg::BYTE_W-1:0]   payload_byte;
   logic                          body_done;
   logic [hcbd_pkg::STATUS_W-1:0] end_status;

   modport source (output valid, output payload_valid, output payload_byte,
                   output body_done, output end_status, input ready);
   modport sink   (input valid, input payload_valid, input payload_byte,
                   input body_done, input end_status, output ready);
endinterface

`default_nettype wire

[rtl/core/http_chunked_body_decoder.sv]
// top level of the http chunked body decoder
//
//   channel  | dir | handshake         | item
//   ---------+-----+-------------------+-------------------------------------------
//   req_if   | in  | valid/ready       | body_byte, body_last
//   rsp_if   | out | valid/ready       | payload_valid, payload_byte, body_done,
//            |     |                   | end_status
//
// one body byte per cycle sustained while rsp_if.ready keeps the result register free;
// an accepted byte passes through the input register, then one pass of the parser
// step logic into the result register. the parser state update sets the rate.
// reset is synchronous and returns the parser to the start of a size line.
// a stalled result holds in the result register; one more item waits in the
// input register, then req_if.ready drops until the result is taken.
`default_nettype none
`include "http_chunked_body_decoder_macros.svh"

module http_chunked_body_decoder #(
   parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   hcbd_req_if.sink   req_if,
   hcbd_rsp_if.source rsp_if
);

   // input register
   logic                        s1_valid_ff, s1_valid_in;
   logic [hcbd_pkg::BYTE_W-1:0] s1_byte_ff;
   logic                        s1_last_ff;

   // parser state
   hcbd_pkg::ctl_type           ctl_ff, ctl_in;
   logic [SIZE_BITS-1:0]        bytes_left_ff, bytes_left_in;
   logic [SIZE_BITS-1:0]        size_accum_ff, size_accum_in;

   // result register
   logic                        out_valid_ff, out_valid_in;
   hcbd_pkg::rslt_type          out_ff, out_in;

   logic                        has_result;
   logic                        out_free;
   logic                        s1_go;
   logic                        req_fire;

   // handshake control
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign s1_go        = s1_valid_ff && out_free;
   assign req_if.ready = !s1_valid_ff || s1_go;
   assign req_fire     = req_if.valid && req_if.ready;

   hcbd_step #(
      .SIZE_BITS (SIZE_BITS)
   ) u_step (
      .body_byte      (s1_byte_ff),
      .body_last      (s1_last_ff),
      .cur_ctl        (ctl_ff),
      .cur_bytes_left (bytes_left_ff),
      .cur_size_accum (size_accum_ff),
      .nxt_ctl        (ctl_in),
      .nxt_bytes_left (bytes_left_in),
      .nxt_size_accum (size_accum_in),
      .has_result     (has_result),
      .result         (out_in)
   );

   // next valid flags
   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_go && has_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control and parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         ctl_ff        <= hcbd_pkg::CTL_RESET;
         bytes_left_ff <= '0;
         size_accum_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_go) begin
            ctl_ff        <= ctl_in;
            bytes_left_ff <= bytes_left_in;
            size_accum_ff <= size_accum_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_if.body_byte;
         s1_last_ff <= req_if.body_last;
      end
      if (s1_go && has_result) begin
         out_ff <= out_in;
      end
   end

   // result channel
   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.payload_valid = out_ff.payload_valid;
   assign rsp_if.payload_byte  = out_ff.payload_byte;
   assign rsp_if.body_done     = out_ff.body_done;
   assign rsp_if.end_status    = out_ff.end_status;

   // checks
   `HCBD_ASSERT_IMPL(a_no_empty_result, clock, reset,
      rsp_if.valid && !rsp_if.payload_valid, rsp_if.body_done,
      "result item carries neither data nor end of body")
   `HCBD_ASSERT_NEXT(a_rearm_after_last, clock, reset, s1_go && s1_last_ff,
      ctl_ff.phase == hcbd_pkg::PH_LINE && size_accum_ff == '0 && bytes_left_ff == '0,
      "parser not rearmed after last byte")
   `HCBD_ASSERT_IMPL(a_data_has_bytes, clock, reset,
      ctl_ff.phase == hcbd_pkg::PH_DATA, bytes_left_ff != '0,
      "data phase with no bytes left")
   `HCBD_ASSERT_IMPL(a_status_code, clock, reset, rsp_if.valid && rsp_if.body_done,
      rsp_if.end_status <= hcbd_pkg::STATUS_W'(hcbd_pkg::ST_OVERFLOW),
      "end status out of range")

endmodule

`default_nettype wire

[rtl/core/hcbd_step.sv]
// per-byte next-state and result logic of the chunked body parser
`default_nettype none

module hcbd_step #(
   parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
   input  wire logic [hcbd_pkg::BYTE_W-1:0] body_byte,
   input  wire logic                        body_last,
   input  wire hcbd_pkg::ctl_type           cur_ctl,
   input  wire logic [SIZE_BITS-1:0]        cur_bytes_left,
   input  wire logic [SIZE_BITS-1:0]        cur_size_accum,
   output hcbd_pkg::ctl_type                nxt_ctl,
   output logic [SIZE_BITS-1:0]             nxt_bytes_left,
   output logic [SIZE_BITS-1:0]             nxt_size_accum,
   output logic                             has_result,
   output hcbd_pkg::rslt_type               result
);

   localparam int HW = hcbd_pkg::HEX_DIGIT_W;

   logic [HW:0]            hex;
   logic                   crlf;
   logic                   acc_ovf;
   hcbd_pkg::status_type   status;

   assign hex     = hcbd_pkg::hex_digit(body_byte);
   assign crlf    = cur_ctl.prior_was_cr && (body_byte == hcbd_pkg::CHAR_LF);
   // a further digit would push bits out of the top nibble
   assign acc_ovf = |cur_size_accum[SIZE_BITS-1 -: HW];

   always_comb begin
      nxt_ctl        = cur_ctl;
      nxt_bytes_left = cur_bytes_left;
      nxt_size_accum = cur_size_accum;
      result         = '0;
      status         = hcbd_pkg::ST_BOUNDARY;

      case (cur_ctl.phase)
         // size line: whitespace, hex digits, then anything up to crlf
         hcbd_pkg::PH_LINE, hcbd_pkg::PH_LINE_OVF: begin
            if (crlf) begin
               if (!cur_ctl.digit_seen) begin
                  nxt_ctl.phase       = hcbd_pkg::PH_STOP;
                  nxt_ctl.stop_status = hcbd_pkg::ST_NODIGIT;
               end else if (cur_ctl.phase == hcbd_pkg::PH_LINE_OVF) begin
                  nxt_ctl.phase       = hcbd_pkg::PH_STOP;
                  nxt_ctl.stop_status = hcbd_pkg::ST_OVERFLOW;
               end else if (cur_size_accum == '0) begin
                  nxt_ctl.phase       = hcbd_pkg::PH_STOP;
                  nxt_ctl.stop_status = hcbd_pkg::ST_ZERO;
               end else begin
                  nxt_bytes_left = cur_size_accum;
                  nxt_ctl.phase  = hcbd_pkg::PH_DATA;
               end
               nxt_size_accum        = '0;
               nxt_ctl.digit_seen    = 1'b0;
               nxt_ctl.number_closed = 1'b0;
               nxt_ctl.prior_was_cr  = 1'b0;
            end else begin
               if (!cur_ctl.number_closed) begin
                  if (!cur_ctl.digit_seen && hcbd_pkg::is_space(body_byte)) begin
                     // leading whitespace, nothing to do
                  end else if (hex[HW]) begin
                     nxt_ctl.digit_seen = 1'b1;
                     if (cur_ctl.phase == hcbd_pkg::PH_LINE) begin
                        if (acc_ovf) begin
                           nxt_ctl.phase = hcbd_pkg::PH_LINE_OVF;
                        end else begin
                           nxt_size_accum = {cur_size_accum[SIZE_BITS-HW-1:0], hex[HW-1:0]};
                        end
                     end
                  end else begin
                     nxt_ctl.number_closed = 1'b1;
                  end
               end
               nxt_ctl.prior_was_cr = (body_byte == hcbd_pkg::CHAR_CR);
            end
         end
         // chunk data passes through
         hcbd_pkg::PH_DATA: begin
            result.payload_valid = 1'b1;
            result.payload_byte  = body_byte;
            if (cur_bytes_left != '0) begin
               nxt_bytes_left = cur_bytes_left - SIZE_BITS'(1);
            end
            if (nxt_bytes_left == '0) begin
               nxt_ctl.phase     = hcbd_pkg::PH_SKIP;
               nxt_ctl.skip_left = hcbd_pkg::SKIP_BYTES;
            end
         end
         // trailing crlf after data, not checked
         hcbd_pkg::PH_SKIP: begin
            if (cur_ctl.skip_left != 2'd0) begin
               nxt_ctl.skip_left = cur_ctl.skip_left - 2'd1;
            end
            if (nxt_ctl.skip_left == 2'd0) begin
               nxt_ctl.phase         = hcbd_pkg::PH_LINE;
               nxt_size_accum        = '0;
               nxt_ctl.digit_seen    = 1'b0;
               nxt_ctl.number_closed = 1'b0;
               nxt_ctl.prior_was_cr  = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // end of body: report status and rearm for the next body
      if (body_last) begin
         case (nxt_ctl.phase)
            hcbd_pkg::PH_LINE, hcbd_pkg::PH_LINE_OVF, hcbd_pkg::PH_SKIP: begin
               status = hcbd_pkg::ST_BOUNDARY;
            end
            hcbd_pkg::PH_DATA: begin
               status = (nxt_bytes_left != '0) ? hcbd_pkg::ST_TRUNC
                                                : hcbd_pkg::ST_BOUNDARY;
            end
            default: begin
               // stop may have been reached on this very byte
               status = nxt_ctl.stop_status;
            end
         endcase
         result.body_done  = 1'b1;
         result.end_status = hcbd_pkg::STATUS_W'(status);
         nxt_ctl           = hcbd_pkg::CTL_RESET;
         nxt_bytes_left    = '0;
         nxt_size_accum    = '0;
      end

      has_result = result.payload_valid || body_last;
   end

endmodule

`default_nettype wire

[tb/testbench.sv]
// testbench for the http chunked body decoder: directed bodies, then random traffic
`timescale 1ns / 1ps

module testbench;

   localparam int SZ_W       = hcbd_pkg::SIZE_BITS_DEFAULT;
   localparam int PHASE_ITEMS = 225;
   localparam int HOLD_AT     = 80;
   localparam int HOLD_CYCLES = 250;

   // one body byte waiting to be sent, with an optional typed expectation
   typedef struct {
      logic [7:0]         b;
      logic               is_last;
      logic               typed;
      hcbd_pkg::rslt_type want;
   } body_item_type;

   logic clock;
   logic reset;

   hcbd_req_if req_if ();
   hcbd_rsp_if rsp_if ();

   http_chunked_body_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   body_item_type      pending_bytes[$];
   hcbd_pkg::rslt_type decoded_due[$];
   int            mismatches = 0;
   int            bytes_taken = 0;
   int            req_idle_pct = 0;
   int            rsp_stall_pct = 0;
   int            idle_plan[4]  = '{0, 61, 0, 37};
   int            stall_plan[4] = '{0, 0, 61, 37};
   logic [7:0]    ws_set[6] = '{8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C, 8'h0A};
   string         ext_text[4] = '{";ext=1", ";q", "\rz", " "};
   string         bad_prefix[4] = '{"+", "-", "0x", ";"};

   // decoder model state
   hcbd_pkg::phase_type  chunk_phase;
   logic [SZ_W-1:0]      chunk_left;
   logic [SZ_W-1:0]      size_acc;
   logic                 got_digit;
   logic                 size_closed;
   logic                 last_was_cr;
   logic [1:0]           skip_cnt;
   hcbd_pkg::status_type halt_code;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #400us;
      $display("testbench: errors");
      $finish;
   end

   function automatic void clear_size_line();
      size_acc    = '0;
      got_digit   = 1'b0;
      size_closed = 1'b0;
      last_was_cr = 1'b0;
   endfunction

   function automatic void parser_reset_state();
      chunk_phase = hcbd_pkg::PH_LINE;
      chunk_left  = '0;
      skip_cnt    = '0;
      halt_code   = hcbd_pkg::ST_BOUNDARY;
      clear_size_line();
   endfunction

   // advance the decoder model by one body byte; returns 1 when an item comes out
   function automatic bit decode_body_byte(input logic [7:0] b, input logic is_last,
                                           output hcbd_pkg::rslt_type r);
      logic       pass;
      logic [2:0] st;
      logic       is_hex;
      logic [3:0] nib;
      logic       ws;
      pass   = 1'b0;
      st     = hcbd_pkg::ST_ZERO;
      is_hex = 1'b1;
      nib    = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         nib = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         nib = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         nib = 4'(b - 8'h37);
      end else begin
         is_hex = 1'b0;
      end
      ws = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);

      case (chunk_phase)
         hcbd_pkg::PH_LINE, hcbd_pkg::PH_LINE_OVF: begin
            if (last_was_cr && b == hcbd_pkg::CHAR_LF) begin
               // end of size line
               if (!got_digit) begin
                  chunk_phase = hcbd_pkg::PH_STOP;
                  halt_code   = hcbd_pkg::ST_NODIGIT;
               end else if (chunk_phase == hcbd_pkg::PH_LINE_OVF) begin
                  chunk_phase = hcbd_pkg::PH_STOP;
                  halt_code   = hcbd_pkg::ST_OVERFLOW;
               end else if (size_acc == 0) begin
                  chunk_phase = hcbd_pkg::PH_STOP;
                  halt_code   = hcbd_pkg::ST_ZERO;
               end else begin
                  chunk_left  = size_acc;
                  chunk_phase = hcbd_pkg::PH_DATA;
               end
               clear_size_line();
            end else begin
               if (!size_closed) begin
                  if (!got_digit && ws) begin
                     // leading whitespace
                  end else if (is_hex) begin
                     got_digit = 1'b1;
                     if (chunk_phase == hcbd_pkg::PH_LINE) begin
                        if (size_acc[SZ_W-1 -: 4] != 0) chunk_phase = hcbd_pkg::PH_LINE_OVF;
                        else size_acc = {size_acc[SZ_W-5:0], nib};
                     end
                  end else begin
                     size_closed = 1'b1;
                  end
               end
               last_was_cr = (b == hcbd_pkg::CHAR_CR);
            end
         end
         hcbd_pkg::PH_DATA: begin
            pass = 1'b1;
            if (chunk_left != 0) chunk_left = chunk_left - SZ_W'(1);
            if (chunk_left == 0) begin
               chunk_phase = hcbd_pkg::PH_SKIP;
               skip_cnt    = hcbd_pkg::SKIP_BYTES;
            end
         end
         hcbd_pkg::PH_SKIP: begin
            if (skip_cnt != 0) skip_cnt = skip_cnt - 2'd1;
            if (skip_cnt == 0) begin
               chunk_phase = hcbd_pkg::PH_LINE;
               clear_size_line();
            end
         end
         default: ;
      endcase

      // status on the final byte
      if (is_last) begin
         if (chunk_phase == hcbd_pkg::PH_LINE || chunk_phase == hcbd_pkg::PH_LINE_OVF ||
             chunk_phase == hcbd_pkg::PH_SKIP)
            st = hcbd_pkg::ST_BOUNDARY;
         else if (chunk_phase == hcbd_pkg::PH_DATA)
            st = (chunk_left != 0) ? hcbd_pkg::ST_TRUNC : hcbd_pkg::ST_BOUNDARY;
         else
            st = halt_code;
      end

      r.payload_valid = pass;
      r.payload_byte  = pass ? b : 8'h00;
      r.body_done     = is_last;
      r.end_status    = st;
      if (is_last) parser_reset_state();
      return pass || is_last;
   endfunction

   task automatic add_byte(input logic [7:0] b);
      body_item_type it;
      it.b       = b;
      it.is_last = 1'b0;
      it.typed   = 1'b0;
      it.want    = '0;
      pending_bytes.insert(pending_bytes.size(), it);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // final byte of a directed body, with its item typed in
   task automatic push_last(input logic [7:0] b, input logic pv,
                            input hcbd_pkg::status_type st);
      body_item_type it;
      it.b                  = b;
      it.is_last            = 1'b1;
      it.typed              = 1'b1;
      it.want.payload_valid = pv;
      it.want.payload_byte  = pv ? b : 8'h00;
      it.want.body_done     = 1'b1;
      it.want.end_status    = st;
      pending_bytes.insert(pending_bytes.size(), it);
   endtask

   // hex digits in mixed case, most significant first
   task automatic add_hex(input logic [63:0] v, input int nd);
      logic [3:0] nib;
      for (int i = nd - 1; i >= 0; i--) begin
         nib = v[4*i +: 4];
         if (nib < 10) add_byte(8'h30 + nib);
         else add_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10);
      end
   endtask

   // size line with optional leading whitespace, leading zeros and extension
   task automatic add_size_line(input logic [63:0] v);
      int nd;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
         add_byte(ws_set[$urandom_range(0, 5)]);
      nd = 1;
      while (nd < 14 && (v >> (4 * nd)) != 0) nd++;
      if ($urandom_range(0, 4) == 0) nd += $urandom_range(1, 2);
      add_hex(v, nd);
      if ($urandom_range(0, 3) == 0) add_text(ext_text[$urandom_range(0, 3)]);
      add_text("\r\n");
   endtask

   // one random body: mostly well-formed chunks, some noise and broken endings
   task automatic add_body();
      int            nch;
      int            sz;
      body_item_type tail;
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(1, 16)) add_byte(8'($urandom_range(0, 255)));
      end else begin
         nch = $urandom_range(0, 3);
         repeat (nch) begin
            sz = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            add_size_line(64'(sz));
            repeat (sz) add_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0) begin
               add_byte(8'($urandom_range(0, 255)));
               add_byte(8'($urandom_range(0, 255)));
            end else begin
               add_text("\r\n");
            end
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               // zero chunk, then trailer bytes that get ignored
               add_size_line(64'd0);
               repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
            end
            6: begin
               // size past the counter width
               add_size_line({28'h0, 4'h1, 32'($urandom)});
               repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
            end
            7: begin
               // sign, 0x or extension before the digits
               add_text(bad_prefix[$urandom_range(0, 3)]);
               add_text("5\r\n");
               repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
            end
            8: begin
               // chunk cut short, sometimes at the largest size
               add_size_line($urandom_range(0, 1) ? 64'hFFFF_FFFF : 64'd5);
               repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
            end
            default: begin
               // body ends inside a size line
               add_hex(64'($urandom_range(0, 255)), $urandom_range(1, 2));
               if ($urandom_range(0, 1)) add_byte(hcbd_pkg::CHAR_CR);
            end
         endcase
      end
      tail = pending_bytes.pop_back();
      tail.is_last = 1'b1;
      pending_bytes.insert(pending_bytes.size(), tail);
   endtask

   // directed bodies
   task automatic load_directed();
      add_text("0\r");
      push_last(hcbd_pkg::CHAR_LF, 1'b0, hcbd_pkg::ST_ZERO);
      add_text("+5\r");
      push_last(hcbd_pkg::CHAR_LF, 1'b0, hcbd_pkg::ST_NODIGIT);
      add_text("1\r\n");
      push_last(8'h41, 1'b1, hcbd_pkg::ST_BOUNDARY);
      add_text("100000000\r");
      push_last(hcbd_pkg::CHAR_LF, 1'b0, hcbd_pkg::ST_OVERFLOW);
      add_text("2\r");
      push_last(hcbd_pkg::CHAR_LF, 1'b0, hcbd_pkg::ST_TRUNC);
      add_text("2\r\n");
      add_byte(8'h00);
      push_last(8'hFF, 1'b1, hcbd_pkg::ST_BOUNDARY);
      push_last(8'hFF, 1'b0, hcbd_pkg::ST_BOUNDARY);
      add_text("\r0x5\r");
      push_last(hcbd_pkg::CHAR_LF, 1'b0, hcbd_pkg::ST_ZERO);
   endtask

   // offer queued bytes with random gaps, predict each accepted item
   task automatic send_pending();
      body_item_type      it;
      hcbd_pkg::rslt_type r;
      bit                 has;
      while (pending_bytes.size() != 0) begin
         it = pending_bytes.pop_front();
         while ($urandom_range(0, 99) < req_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
         req_if.valid     <= 1'b1;
         req_if.body_byte <= it.b;
         req_if.body_last <= it.is_last;
         @(posedge clock);
         while (!req_if.ready) @(posedge clock);
         has = decode_body_byte(it.b, it.is_last, r);
         if (it.typed) decoded_due.insert(decoded_due.size(), it.want);
         else if (has) decoded_due.insert(decoded_due.size(), r);
         bytes_taken <= bytes_taken + 1;
      end
   endtask

   // main sequence
   initial begin
      parser_reset_state();
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.body_byte <= 8'h00;
      req_if.body_last <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      load_directed();
      send_pending();

      for (int ph = 0; ph < 4; ph++) begin
         req_idle_pct  = idle_plan[ph];
         rsp_stall_pct = stall_plan[ph];
         while (pending_bytes.size() < PHASE_ITEMS) add_body();
         send_pending();
      end
      req_if.valid <= 1'b0;

      while (decoded_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // receiver: random stalls, plus one long hold-off to back up the input
   initial begin : drive_ready
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && bytes_taken >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // compare each accepted item with the oldest prediction
   always @(posedge clock) begin : check_results
      hcbd_pkg::rslt_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (decoded_due.size() == 0) begin
            $display("%0t: unexpected decoded item valid=%0b byte=%02h done=%0b status=%0d",
                     $time, rsp_if.payload_valid, rsp_if.payload_byte,
                     rsp_if.body_done, rsp_if.end_status);
            mismatches++;
         end else begin
            want = decoded_due.pop_front();
            if (rsp_if.payload_valid !== want.payload_valid ||
                rsp_if.payload_byte  !== want.payload_byte  ||
                rsp_if.body_done     !== want.body_done     ||
                rsp_if.end_status    !== want.end_status) begin
               $display("%0t: expected valid=%0b byte=%02h done=%0b status=%0d, %s",
                        $time, want.payload_valid, want.payload_byte, want.body_done,
                        want.end_status, "actual follows");
               $display("%0t: actual   valid=%0b byte=%02h done=%0b status=%0d",
                        $time, rsp_if.payload_valid, rsp_if.payload_byte,
                        rsp_if.body_done, rsp_if.end_status);
               mismatches++;
            end
         end
      end
   end

endmodule
